>>> hdl/lzw_trained_dict_encoder_core_assert.svh
// assertion macros for the lzw trained dictionary encoder checker
`ifndef LZW_TRAINED_DICT_ENCODER_CORE_ASSERT_SVH
`define LZW_TRAINED_DICT_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define LZWTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lzwtd port check failed");

// next-cycle implication, sampled on aclk, off during reset
`define LZWTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lzwtd port check failed");

`endif

>>> hdl/lzwtd_pkg.sv
// shared types and constants of the lzw trained dictionary encoder
package lzwtd_pkg;

    // operation carried in the low bits of s_tuser
    typedef enum logic [1:0] {
        FN_TRAIN  = 2'd0,
        FN_ENCODE = 2'd1,
        FN_FLUSH  = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    localparam int BYTE_W     = 8;
    localparam int OUT_CODE_W = 12;
    localparam int FIRST_FREE = 256;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // bit positions inside the stream words
    localparam int S_TUSER_FIRST_BIT = 2;
    localparam int M_TDATA_FULL_BIT  = OUT_CODE_W;

endpackage

>>> hdl/lzw_trained_dict_encoder_core.sv
// lzw encoder over a trained dictionary, trie held in block memories
// Each item goes from acceptance to decision in order: the child table
// is read at the accepting edge with the current code and the new byte, the code it
// returns addresses the back-pointer table in the next cycle, and the decision state
// then decides, updates the current code and, on a training miss with room, writes both
// tables. A new item is taken in the cycle after the decision, so no new item is
// taken while one is in flight, set by the two dependent memory reads. An item that
// emits a code (encode miss, flush of an open stream) holds in its decision cycle while
// the previous result still sits unread in the output register. The child table has
// 2^(CODE_BITS+8) entries and is never cleared: an entry counts as present only when
// its code lies between 256 and the next free code and the back-pointer table,
// filled in step with the next free code, points back at the same prefix and byte.
// So the block is ready right after reset, with no clearing pass. Inputs: s_tdata
// holds the byte, s_tuser the operation (train, encode, flush) and the start-of-stream
// flag. Results: s_tdata-style word m_tdata with the emitted code and a flag that the
// dictionary is full.
module lzw_trained_dict_encoder_core #(
    parameter int CODE_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input item channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lzwtd_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic [lzwtd_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] func, [2] first
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lzwtd_pkg::M_TDATA_W-1:0]  m_tdata    // [11:0] out_code, [12] dict_full
);
    import lzwtd_pkg::*;

    localparam int SLOT_W      = CODE_BITS + BYTE_W;
    localparam int CHILD_DEPTH = 1 << SLOT_W;
    localparam int CODE_DEPTH  = 1 << CODE_BITS;

    // one-hot sequencer: accept, back-pointer lookup, decide
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOOK  = 3'b010,
        ST_CHECK = 3'b100
    } state_t;

    // trie memories: child code by (prefix, byte), and the slot that made each code
    logic [CODE_BITS-1:0] child_mem [0:CHILD_DEPTH-1];
    logic [SLOT_W-1:0]    rev_mem   [0:CODE_DEPTH-1];

    state_t               state_reg, state_next;
    logic [CODE_BITS-1:0] current_code_reg, current_code_next;
    logic [CODE_BITS-1:0] next_free_reg, next_free_next;
    logic                 stream_open_reg, stream_open_next;

    // item held while it is looked up
    func_t                func_reg;
    logic                 first_reg;
    logic [SLOT_W-1:0]    slot_reg;

    // memory read data
    logic [CODE_BITS-1:0] child_rd_reg;
    logic [SLOT_W-1:0]    rev_rd_reg;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_CODE_W-1:0] m_code_reg, m_code_next;
    logic                  m_full_reg, m_full_next;

    logic                 s_accept;
    logic [SLOT_W-1:0]    rd_slot;
    logic                 hit;
    logic                 dict_full;
    logic                 out_free;
    logic                 ins_we;
    logic [OUT_CODE_W+CODE_BITS-1:0] code_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign rd_slot  = {current_code_reg, s_tdata[BYTE_W-1:0]};

    // a stored child is real only if it is an issued code that points back here
    assign hit = (child_rd_reg >= CODE_BITS'(FIRST_FREE)) &&
                 (child_rd_reg < next_free_reg) &&
                 (rev_rd_reg == slot_reg);

    // next free stops at the top code, no more room from there on
    assign dict_full = &next_free_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign code_wide = {{OUT_CODE_W{1'b0}}, current_code_reg};

    always_comb begin
        state_next        = state_reg;
        current_code_next = current_code_reg;
        next_free_next    = next_free_reg;
        stream_open_next  = stream_open_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_code_next       = m_code_reg;
        m_full_next       = m_full_reg;
        ins_we            = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_IDLE;
                case (func_reg)
                    FN_FLUSH: begin
                        if (stream_open_reg) begin
                            if (out_free) begin
                                m_valid_next     = 1'b1;
                                m_code_next      = code_wide[OUT_CODE_W-1:0];
                                m_full_next      = dict_full;
                                stream_open_next = 1'b0;
                            end else begin
                                state_next = ST_CHECK;
                            end
                        end
                    end
                    FN_TRAIN, FN_ENCODE: begin
                        if (first_reg || !stream_open_reg) begin
                            // start of stream: the byte becomes the current code
                            current_code_next = CODE_BITS'(slot_reg[BYTE_W-1:0]);
                            stream_open_next  = 1'b1;
                        end else if (hit) begin
                            current_code_next = child_rd_reg;
                        end else if (func_reg == FN_TRAIN) begin
                            if (!dict_full) begin
                                ins_we         = 1'b1;
                                next_free_next = next_free_reg + CODE_BITS'(1);
                            end
                            current_code_next = CODE_BITS'(slot_reg[BYTE_W-1:0]);
                        end else if (out_free) begin
                            m_valid_next      = 1'b1;
                            m_code_next       = code_wide[OUT_CODE_W-1:0];
                            m_full_next       = dict_full;
                            current_code_next = CODE_BITS'(slot_reg[BYTE_W-1:0]);
                        end else begin
                            state_next = ST_CHECK;
                        end
                    end
                    default: begin
                        // unused operation, no effect
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            current_code_reg <= '0;
            next_free_reg    <= CODE_BITS'(FIRST_FREE);
            stream_open_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            current_code_reg <= current_code_next;
            next_free_reg    <= next_free_next;
            stream_open_reg  <= stream_open_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        m_code_reg <= m_code_next;
        m_full_reg <= m_full_next;
        if (s_accept) begin
            func_reg  <= func_t'(s_tuser[1:0]);
            first_reg <= s_tuser[S_TUSER_FIRST_BIT];
            slot_reg  <= rd_slot;
        end
    end

    // child table: read at acceptance, written on a training insert
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            child_rd_reg <= child_mem[rd_slot];
        end
        if (ins_we) begin
            child_mem[slot_reg] <= next_free_reg;
        end
    end

    // back-pointer table: read with the child code, written with the new code
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            rev_rd_reg <= rev_mem[child_rd_reg];
        end
        if (ins_we) begin
            rev_mem[next_free_reg] <= slot_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_CODE_W-1){1'b0}}, m_full_reg, m_code_reg};

endmodule

>>> hdl/lzwtd_checker.sv
// port-level checker for the lzw trained dictionary encoder, bound to the top level
module lzwtd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lzwtd_pkg::M_TDATA_W-1:0] m_tdata
);
    import lzwtd_pkg::*;

`include "lzw_trained_dict_encoder_core_assert.svh"

    // a stalled result holds its word
    `LZWTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // each item keeps the input closed while it is looked up and decided
    `LZWTD_ASSERT_NEXT(a_item_busy, s_tvalid && s_tready, !s_tready ##1 !s_tready)

    // a new result only comes out of a decision cycle, never while idle
    `LZWTD_ASSERT_SAME(a_result_origin, $rose(m_tvalid), !$past(s_tready))

endmodule

bind lzw_trained_dict_encoder_core lzwtd_checker u_lzwtd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
